// ===== sv/wlsf_pkg.sv =====
`default_nettype none

package wlsf_pkg;

  localparam int unsigned RingDepthDef = 64;

  // item field widths
  localparam int unsigned XW      = 16;
  localparam int unsigned YW      = 24;
  localparam int unsigned TW      = 63;
  localparam int unsigned OutW    = 32;
  localparam int unsigned RemW    = 6;
  localparam int unsigned CntOutW = 7;

  // configuration registers
  localparam int unsigned AgeW    = 40;
  localparam int unsigned EpsW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AgeW-1:0]    MaxAgeRst = 40'd5000000000;
  localparam logic [EpsW-1:0]    DetEpsRst = 32'd1;
  localparam logic [CfgIdxW-1:0] RegMaxAge = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDetEps = 2'd1;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [TW-1:0] t;
  } entry_t;

  typedef struct packed {
    logic we;
    logic clr;
  } ring_ctrl_t;

  typedef struct packed {
    logic clr;
    logic step;
    logic is_div;
    logic din;
  } alu_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/wlsf_if.sv =====
`default_nettype none

interface wlsf_in_if;
  import wlsf_pkg::*;
  logic          valid;
  logic          ready;
  logic [XW-1:0] size_log;
  logic [YW-1:0] rtt;
  logic [TW-1:0] time_ns;
  modport source (output valid, size_log, rtt, time_ns, input ready);
  modport sink (input valid, size_log, rtt, time_ns, output ready);
endinterface

interface wlsf_out_if;
  import wlsf_pkg::*;
  logic               valid;
  logic               ready;
  logic [OutW-1:0]    slope;
  logic [OutW-1:0]    offset;
  logic [RemW-1:0]    removed_count;
  logic [CntOutW-1:0] sample_count;
  modport source (output valid, slope, offset, removed_count, sample_count, input ready);
  modport sink (input valid, slope, offset, removed_count, sample_count, output ready);
endinterface

interface wlsf_cfg_if;
  import wlsf_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [AgeW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/wlsf_ring.sv =====
`default_nettype none

module wlsf_ring #(
  parameter int unsigned RING_DEPTH = wlsf_pkg::RingDepthDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wlsf_pkg::ring_ctrl_t             ctrl_i,
  input  wire [$clog2(RING_DEPTH)-1:0]     waddr_i,
  input  wlsf_pkg::entry_t                 wdata_i,
  input  wire [$clog2(RING_DEPTH)-1:0]     caddr_i,
  input  wire [$clog2(RING_DEPTH)-1:0]     raddr_i,
  output wlsf_pkg::entry_t                 rdata_o,
  output logic [RING_DEPTH-1:0]            valid_o
);
  import wlsf_pkg::*;

  entry_t                mem_q [RING_DEPTH];
  entry_t                rdata_q;
  logic [RING_DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // occupancy bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctrl_i.we) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.clr) begin
        valid_q[caddr_i] <= 1'b0;
      end
    end
  end

  assign rdata_o = rdata_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== sv/wlsf_alu.sv =====
`default_nettype none

module wlsf_alu #(
  parameter int unsigned AccW = 69
) (
  input  wire                     clk_i,
  input  wlsf_pkg::alu_ctrl_t     ctrl_i,
  input  wire [AccW-1:0]          opnd_i,
  output logic [AccW-1:0]         acc_o,
  output logic [AccW-2:0]         quo_o
);
  import wlsf_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-2:0] quo_q;
  logic [AccW-1:0] sh;
  logic [AccW-1:0] addend;
  logic [AccW:0]   sum;
  logic            qbit;

  // shift-add multiply step or restoring divide step, one adder
  always_comb begin
    sh     = {acc_q[AccW-2:0], ctrl_i.is_div & ctrl_i.din};
    addend = ctrl_i.is_div ? ~opnd_i : (ctrl_i.din ? opnd_i : '0);
    sum    = {1'b0, sh} + {1'b0, addend} + (AccW+1)'(ctrl_i.is_div);
    qbit   = ctrl_i.is_div & sum[AccW];
    if (ctrl_i.is_div) begin
      acc_d = qbit ? sum[AccW-1:0] : sh;
    end else begin
      acc_d = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
      quo_q <= {quo_q[AccW-3:0], qbit};
    end
  end

  assign acc_o = acc_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/windowed_least_squares_line_fit.sv =====
`default_nettype none

// Sliding-window least-squares line fit. Each input request carries a log
// size x, a round-trip time y and a timestamp; the block adds it to exact
// integer sums, stores it in a ring of RING_DEPTH slots (overwriting and
// subtracting the oldest slot when the ring is full), then walks back through
// the ring, dropping every entry older than max_age_ns, and finally solves
// the 2x2 normal equations for slope and offset with truncating division,
// saturated to signed 32 bits. When the determinant is at or below
// det_epsilon the slope is 0 and the offset is the mean of y. One request is
// in work at a time and the input is not ready meanwhile; a finished result
// sits in an output register, so the next request is taken while it waits.
// Each request also works through every entry visited in the scan, every
// entry dropped and, when a live slot is overwritten, its removal, then the
// fit, and it waits while the output register is full. The fit runs on one
// shared shift-add / restoring-divide unit at one bit per cycle; it is
// dominated, outside the singular case, by the two divisions of a
// 2*log2(depth)+56 bit numerator. Registers may be written only while the
// block is idle; the configuration port is always ready.

module windowed_least_squares_line_fit #(
  parameter int unsigned RING_DEPTH = wlsf_pkg::RingDepthDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  wlsf_in_if.sink           in_i,
  wlsf_out_if.source        res_o,
  wlsf_cfg_if.sink          cfg_i
);
  import wlsf_pkg::*;

  // sum and product widths follow the ring depth
  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned XSW  = XW + AW;
  localparam int unsigned XXW  = 2 * XW + AW;
  localparam int unsigned YSW  = YW + AW;
  localparam int unsigned XYW  = XW + YW + AW;
  localparam int unsigned PW   = XXW + YSW;
  localparam int unsigned DW   = CW + XXW;
  localparam int unsigned AccW = PW + 1;
  localparam int unsigned CntW = $clog2(PW + 1);

  typedef enum logic [11:0] {
    S_IDLE     = 12'h001,
    S_OLD      = 12'h002,
    S_NEWP     = 12'h004,
    S_ACC      = 12'h008,
    S_SCAN_RD  = 12'h010,
    S_SCAN_CHK = 12'h020,
    S_LOOP     = 12'h040,
    S_DONE     = 12'h080,
    S_DET      = 12'h100,
    S_CHECK    = 12'h200,
    S_MAG      = 12'h400,
    S_OUT      = 12'h800
  } state_e;

  // operations run on the shared unit
  typedef enum logic [8:0] {
    J_ND      = 9'h001,
    J_XX2     = 9'h002,
    J_MEAN    = 9'h004,
    J_P_OFF   = 9'h008,
    J_Q_OFF   = 9'h010,
    J_DIV_OFF = 9'h020,
    J_P_SLP   = 9'h040,
    J_Q_SLP   = 9'h080,
    J_DIV_SLP = 9'h100
  } job_e;

  // what a sum update belongs to
  typedef enum logic [2:0] {
    P_OLD  = 3'b001,
    P_NEW  = 3'b010,
    P_SCAN = 3'b100
  } phase_e;

  state_e state_q, state_d;
  job_e   job_q, job_d, nxt_job;
  phase_e phase_q, phase_d;

  logic [AW-1:0]  slot_q, slot_d, idx_q, idx_d, nxt_slot;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  removed_q, removed_d;
  logic [CW-1:0]  n_q, n_d;
  logic [XSW-1:0] sx_q, sx_d;
  logic [XXW-1:0] sxx_q, sxx_d;
  logic [YSW-1:0] sy_q, sy_d;
  logic [XYW-1:0] sxy_q, sxy_d;
  logic [AgeW-1:0] max_age_q;
  logic [EpsW-1:0] eps_q;

  logic [XW-1:0]      x_q, x_d, ux_q, ux_d;
  logic [YW-1:0]      y_q, y_d, uy_q, uy_d;
  logic [TW-1:0]      t_q, t_d;
  logic [2*XW-1:0]    pxx_q, pxx_d;
  logic [XW+YW-1:0]   pxy_q, pxy_d;
  logic               sub_q, sub_d;
  logic [DW-1:0]      nd_q, nd_d, xx2_q, xx2_d, det_q, det_d;
  logic [PW-1:0]      p_q, p_d, src_q, src_d;
  logic               neg_q, neg_d;
  logic [AccW-1:0]    opnd_q, opnd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [OutW-1:0]    slope_q, slope_d, offset_q, offset_d;

  logic               out_valid_q, out_valid_d;
  logic [OutW-1:0]    out_slope_q, out_offset_q;
  logic [RemW-1:0]    out_rem_q;
  logic [CntOutW-1:0] out_cnt_q;
  logic               out_load;

  ring_ctrl_t            ring_ctrl;
  entry_t                rdata;
  entry_t                wdata;
  logic [RING_DEPTH-1:0] valid;

  alu_ctrl_t       alu_ctrl;
  logic [AccW-1:0] acc;
  logic [PW-1:0]   quo;
  logic [PW-1:0]   acc_pw;
  logic [PW-1:0]   mag;

  logic               prod_rd, load_prod, start, in_take, expired;
  logic [XW-1:0]      px;
  logic [YW-1:0]      py;
  logic [2*XW-1:0]    prod_xx;
  logic [XW+YW-1:0]   prod_xy;
  logic [TW:0]        tdiff;

  function automatic logic [OutW-1:0] sat_q(input logic neg, input logic [PW-1:0] q);
    logic [OutW-1:0] r;
    if (!neg) begin
      r = (|q[PW-1:OutW-1]) ? {1'b0, {(OutW-1){1'b1}}} : q[OutW-1:0];
    end else if ((|q[PW-1:OutW]) || (q[OutW-1] && (|q[OutW-2:0]))) begin
      r = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      r = -q[OutW-1:0];
    end
    return r;
  endfunction

  wlsf_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .waddr_i(slot_q),
    .wdata_i(wdata),
    .caddr_i(idx_q),
    .raddr_i(raddr),
    .rdata_o(rdata),
    .valid_o(valid)
  );

  wlsf_alu #(
    .AccW(AccW)
  ) u_alu (
    .clk_i (clk_i),
    .ctrl_i(alu_ctrl),
    .opnd_i(opnd_q),
    .acc_o (acc),
    .quo_o (quo)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_take     = in_i.valid && (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign wdata = '{x: x_q, y: y_q, t: t_q};
  assign acc_pw = acc[PW-1:0];

  // next write slot wraps at the ring depth
  assign nxt_slot = (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  // per-sample products for the sums, from the ring or the new sample
  assign px      = prod_rd ? rdata.x : x_q;
  assign py      = prod_rd ? rdata.y : y_q;
  assign prod_xx = (2*XW)'(px) * (2*XW)'(px);
  assign prod_xy = (XW+YW)'(px) * (XW+YW)'(py);

  // an entry newer than the new sample never expires
  assign tdiff   = {1'b0, t_q} - {1'b0, rdata.t};
  assign expired = !tdiff[TW] && (tdiff[TW-1:0] > TW'(max_age_q));

  // magnitude of p - q for the signed quotients
  assign mag = (p_q < acc_pw) ? (acc_pw - p_q) : (p_q - acc_pw);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    phase_d     = phase_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    removed_d   = removed_q;
    n_d         = n_q;
    sx_d        = sx_q;
    sxx_d       = sxx_q;
    sy_d        = sy_q;
    sxy_d       = sxy_q;
    x_d         = x_q;
    y_d         = y_q;
    t_d         = t_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    pxx_d       = pxx_q;
    pxy_d       = pxy_q;
    sub_d       = sub_q;
    nd_d        = nd_q;
    xx2_d       = xx2_q;
    det_d       = det_q;
    p_d         = p_q;
    neg_d       = neg_q;
    src_d       = src_q;
    opnd_d      = opnd_q;
    cnt_d       = cnt_q;
    slope_d     = slope_q;
    offset_d    = offset_q;
    raddr       = idx_q;
    ring_ctrl   = '0;
    alu_ctrl    = '0;
    prod_rd     = 1'b0;
    load_prod   = 1'b0;
    start       = 1'b0;
    nxt_job     = job_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          x_d       = in_i.size_log;
          y_d       = in_i.rtt;
          t_d       = in_i.time_ns;
          slot_d    = nxt_slot;
          raddr     = nxt_slot;
          removed_d = '0;
          state_d   = S_OLD;
        end
      end
      S_OLD: begin
        // a full ring drops the slot about to be overwritten first
        if (valid[slot_q]) begin
          prod_rd   = 1'b1;
          load_prod = 1'b1;
          sub_d     = 1'b1;
          phase_d   = P_OLD;
          state_d   = S_ACC;
        end else begin
          load_prod    = 1'b1;
          sub_d        = 1'b0;
          phase_d      = P_NEW;
          ring_ctrl.we = 1'b1;
          state_d      = S_ACC;
        end
      end
      S_NEWP: begin
        load_prod    = 1'b1;
        sub_d        = 1'b0;
        phase_d      = P_NEW;
        ring_ctrl.we = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        if (sub_q) begin
          n_d   = n_q - 1'b1;
          sx_d  = sx_q - XSW'(ux_q);
          sxx_d = sxx_q - XXW'(pxx_q);
          sy_d  = sy_q - YSW'(uy_q);
          sxy_d = sxy_q - XYW'(pxy_q);
        end else begin
          n_d   = n_q + 1'b1;
          sx_d  = sx_q + XSW'(ux_q);
          sxx_d = sxx_q + XXW'(pxx_q);
          sy_d  = sy_q + YSW'(uy_q);
          sxy_d = sxy_q + XYW'(pxy_q);
        end
        unique case (phase_q)
          P_OLD: state_d = S_NEWP;
          P_NEW: begin
            idx_d   = (slot_q == '0) ? AW'(RING_DEPTH - 1) : slot_q - 1'b1;
            state_d = S_SCAN_RD;
          end
          P_SCAN: begin
            idx_d   = (idx_q == '0) ? AW'(RING_DEPTH - 1) : idx_q - 1'b1;
            state_d = S_SCAN_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        // scan ends at an empty slot or back at the new one
        if (!valid[idx_q] || (idx_q == slot_q)) begin
          start   = 1'b1;
          nxt_job = J_ND;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (expired) begin
          prod_rd       = 1'b1;
          load_prod     = 1'b1;
          sub_d         = 1'b1;
          phase_d       = P_SCAN;
          ring_ctrl.clr = 1'b1;
          removed_d     = removed_q + 1'b1;
          state_d       = S_ACC;
        end else begin
          idx_d   = (idx_q == '0) ? AW'(RING_DEPTH - 1) : idx_q - 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_LOOP: begin
        alu_ctrl.step   = 1'b1;
        alu_ctrl.is_div = (job_q == J_MEAN) || (job_q == J_DIV_OFF) ||
                          (job_q == J_DIV_SLP);
        alu_ctrl.din    = src_q[PW-1];
        src_d           = src_q << 1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        unique case (job_q)
          J_ND: begin
            nd_d    = DW'(acc);
            start   = 1'b1;
            nxt_job = J_XX2;
          end
          J_XX2: begin
            xx2_d   = DW'(acc);
            state_d = S_DET;
          end
          J_MEAN: begin
            offset_d = sat_q(1'b0, quo);
            slope_d  = '0;
            state_d  = S_OUT;
          end
          J_P_OFF: begin
            p_d     = acc_pw;
            start   = 1'b1;
            nxt_job = J_Q_OFF;
          end
          J_Q_OFF, J_Q_SLP: begin
            state_d = S_MAG;
          end
          J_DIV_OFF: begin
            offset_d = sat_q(neg_q, quo);
            start    = 1'b1;
            nxt_job  = J_P_SLP;
          end
          J_P_SLP: begin
            p_d     = acc_pw;
            start   = 1'b1;
            nxt_job = J_Q_SLP;
          end
          J_DIV_SLP: begin
            slope_d = sat_q(neg_q, quo);
            state_d = S_OUT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DET: begin
        det_d   = (nd_q >= xx2_q) ? nd_q - xx2_q : '0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // near-singular fit falls back to the mean of y
        if (det_q <= DW'(eps_q)) begin
          if (n_q == '0) begin
            slope_d  = '0;
            offset_d = '0;
            state_d  = S_OUT;
          end else begin
            start   = 1'b1;
            nxt_job = J_MEAN;
          end
        end else begin
          start   = 1'b1;
          nxt_job = J_P_OFF;
        end
      end
      S_MAG: begin
        neg_d   = (p_q < acc_pw);
        start   = 1'b1;
        nxt_job = (job_q == J_Q_OFF) ? J_DIV_OFF : J_DIV_SLP;
      end
      S_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_prod) begin
      ux_d  = px;
      uy_d  = py;
      pxx_d = prod_xx;
      pxy_d = prod_xy;
    end

    // operands of the next job: multiplier or numerator goes MSB first
    if (start) begin
      alu_ctrl.clr = 1'b1;
      job_d        = nxt_job;
      state_d      = S_LOOP;
      unique case (nxt_job)
        J_ND: begin
          src_d  = PW'(n_q) << (PW - CW);
          opnd_d = AccW'(sxx_q);
          cnt_d  = CntW'(CW);
        end
        J_XX2: begin
          src_d  = PW'(sx_q) << (PW - XSW);
          opnd_d = AccW'(sx_q);
          cnt_d  = CntW'(XSW);
        end
        J_MEAN: begin
          src_d  = PW'(sy_q) << (PW - YSW);
          opnd_d = AccW'(n_q);
          cnt_d  = CntW'(YSW);
        end
        J_P_OFF: begin
          src_d  = PW'(sy_q) << (PW - YSW);
          opnd_d = AccW'(sxx_q);
          cnt_d  = CntW'(YSW);
        end
        J_Q_OFF: begin
          src_d  = PW'(sx_q) << (PW - XSW);
          opnd_d = AccW'(sxy_q);
          cnt_d  = CntW'(XSW);
        end
        J_P_SLP: begin
          src_d  = PW'(n_q) << (PW - CW);
          opnd_d = AccW'(sxy_q);
          cnt_d  = CntW'(CW);
        end
        J_Q_SLP: begin
          src_d  = PW'(sx_q) << (PW - XSW);
          opnd_d = AccW'(sy_q);
          cnt_d  = CntW'(XSW);
        end
        J_DIV_OFF, J_DIV_SLP: begin
          src_d  = mag;
          opnd_d = AccW'(det_q);
          cnt_d  = CntW'(PW);
        end
        default: begin
          cnt_d = CntW'(1);
        end
      endcase
    end
  end

  // control state, sums and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_ND;
      phase_q     <= P_NEW;
      slot_q      <= AW'(RING_DEPTH - 1);
      idx_q       <= '0;
      removed_q   <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      sx_q        <= '0;
      sxx_q       <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      max_age_q   <= MaxAgeRst;
      eps_q       <= DetEpsRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      removed_q   <= removed_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      sx_q        <= sx_d;
      sxx_q       <= sxx_d;
      sy_q        <= sy_d;
      sxy_q       <= sxy_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegMaxAge: max_age_q <= cfg_i.data;
          RegDetEps: eps_q     <= cfg_i.data[EpsW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    t_q      <= t_d;
    ux_q     <= ux_d;
    uy_q     <= uy_d;
    pxx_q    <= pxx_d;
    pxy_q    <= pxy_d;
    sub_q    <= sub_d;
    nd_q     <= nd_d;
    xx2_q    <= xx2_d;
    det_q    <= det_d;
    p_q      <= p_d;
    neg_q    <= neg_d;
    src_q    <= src_d;
    opnd_q   <= opnd_d;
    slope_q  <= slope_d;
    offset_q <= offset_d;
    if (out_load) begin
      out_slope_q  <= slope_q;
      out_offset_q <= offset_q;
      out_rem_q    <= RemW'(removed_q);
      out_cnt_q    <= CntOutW'(n_q);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.slope         = out_slope_q;
  assign res_o.offset        = out_offset_q;
  assign res_o.removed_count = out_rem_q;
  assign res_o.sample_count  = out_cnt_q;

  // occupied slots and sample count agree between requests
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid) == n_q))
    else $error("sample count differs from occupied slots");

  // the shared unit never runs a job with no steps left
  a_loop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOP) |-> (cnt_q != '0))
    else $error("shared unit stepping with zero count");

  // a result appears only from the output state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

endmodule

`default_nettype wire

// ===== verif/tb_windowed_least_squares_line_fit.sv =====
`timescale 1ns / 100ps

module tb_windowed_least_squares_line_fit;
  import wlsf_pkg::*;

  localparam int unsigned Depth = RingDepthDef;
  localparam int unsigned HoldCycles = 2000;

  // one fit result as the block reports it
  typedef struct {
    logic signed [OutW-1:0] slope;
    logic signed [OutW-1:0] offset;
    logic [RemW-1:0]        removed;
    logic [CntOutW-1:0]     count;
  } fit_t;

  // a sample request plus an optional hand-typed expectation
  typedef struct {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [TW-1:0] t;
    bit            pinned;
    fit_t          fit;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  wlsf_in_if  in_if ();
  wlsf_out_if res_if ();
  wlsf_cfg_if cfg_if ();

  windowed_least_squares_line_fit #(.RING_DEPTH(Depth)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the window state and registers
  longint unsigned max_age;
  longint unsigned det_eps;
  logic [XW-1:0]   ring_x [Depth];
  logic [YW-1:0]   ring_y [Depth];
  longint unsigned ring_t [Depth];
  bit              ring_live [Depth];
  int unsigned     wr_slot;
  longint unsigned n_sum, x_sum, xx_sum, y_sum, xy_sum;

  fit_t    fits_due [$];     // expected fits, oldest first
  sample_t sent_log [$];     // requests offered, oldest first
  int      errors = 0;
  bit      idle_on = 1'b1;
  int      hold_req = 0;     // receiver hold-off request, in cycles

  function automatic void drop_entry(int unsigned i);
    longint unsigned x, y;
    x = ring_x[i];
    y = ring_y[i];
    n_sum  -= 1;
    x_sum  -= x;
    xx_sum -= x * x;
    y_sum  -= y;
    xy_sum -= x * y;
    ring_live[i] = 1'b0;
    ring_x[i] = '0;
    ring_y[i] = '0;
    ring_t[i] = 0;
  endfunction

  // (p - q) / det truncated toward zero, clamped to signed 32 bits
  function automatic logic [OutW-1:0] clamp_quot(logic [127:0] p, logic [127:0] q,
                                                  longint unsigned det);
    logic [127:0] mag;
    bit neg;
    neg = p < q;
    mag = (neg ? q - p : p - q) / {64'd0, det};
    if (!neg) return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    return (mag > 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
  endfunction

  function automatic fit_t fit_window(logic [XW-1:0] xi, logic [YW-1:0] yi, logic [TW-1:0] ti);
    fit_t r;
    int unsigned cur, i, removed;
    longint unsigned x, y, t, nd, xx2, det, m;
    x = xi;
    y = yi;
    t = {1'b0, ti};
    removed = 0;
    cur = (wr_slot + 1) % Depth;
    wr_slot = cur;
    // full ring: the overwritten slot leaves the sums silently
    if (ring_live[cur]) drop_entry(cur);
    n_sum  += 1;
    x_sum  += x;
    xx_sum += x * x;
    y_sum  += y;
    xy_sum += x * y;
    ring_x[cur] = xi;
    ring_y[cur] = yi;
    ring_t[cur] = t;
    ring_live[cur] = 1'b1;
    // walk back until an empty slot or all the way round
    i = (cur == 0) ? Depth - 1 : cur - 1;
    while (ring_live[i] && i != cur) begin
      // newer-than-now entries have no age
      if (t >= ring_t[i] && t - ring_t[i] > max_age) begin
        drop_entry(i);
        removed++;
      end
      i = (i == 0) ? Depth - 1 : i - 1;
    end
    nd  = n_sum * xx_sum;
    xx2 = x_sum * x_sum;
    det = (nd >= xx2) ? nd - xx2 : 0;
    r.slope = '0;
    r.offset = '0;
    if (det <= det_eps) begin
      // singular: flat line through the mean
      if (n_sum != 0) begin
        m = y_sum / n_sum;
        r.offset = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      end
    end else begin
      r.offset = clamp_quot(128'(xx_sum) * 128'(y_sum), 128'(x_sum) * 128'(xy_sum), det);
      r.slope  = clamp_quot(128'(n_sum) * 128'(xy_sum), 128'(x_sum) * 128'(y_sum), det);
    end
    r.removed = removed[RemW-1:0];
    r.count = n_sum[CntOutW-1:0];
    return r;
  endfunction

  // accepted request: predict, or take the typed expectation
  always @(posedge clk_i) begin
    sample_t s;
    fit_t f;
    if (rst_ni && in_if.valid && in_if.ready) begin
      s = sent_log.pop_front();
      f = fit_window(in_if.size_log, in_if.rtt, in_if.time_ns);
      fits_due.push_back(s.pinned ? s.fit : f);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fit_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (fits_due.size() == 0) begin
        $error("unexpected fit result");
        errors++;
      end else begin
        e = fits_due.pop_front();
        if (res_if.slope !== e.slope) begin
          $error("slope: expected %0d, got %0d", e.slope, $signed(res_if.slope));
          errors++;
        end
        if (res_if.offset !== e.offset) begin
          $error("offset: expected %0d, got %0d", e.offset, $signed(res_if.offset));
          errors++;
        end
        if (res_if.removed_count !== e.removed) begin
          $error("removed_count: expected %0d, got %0d", e.removed, res_if.removed_count);
          errors++;
        end
        if (res_if.sample_count !== e.count) begin
          $error("sample_count: expected %0d, got %0d", e.count, res_if.sample_count);
          errors++;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      res_if.ready <= 1'b0;
      repeat (hold_left) @(posedge clk_i);
    end
    res_if.ready <= idle_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  // register write, only while the block is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint unsigned val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[AgeW-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == RegMaxAge) max_age = val & 64'hFF_FFFF_FFFF;
    else if (idx == RegDetEps) det_eps = val & 64'hFFFF_FFFF;
  endtask

  // offer one sample request and hold it until taken
  task automatic send_sample(sample_t s);
    if (idle_on && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    sent_log.push_back(s);
    in_if.valid    <= 1'b1;
    in_if.size_log <= s.x;
    in_if.rtt      <= s.y;
    in_if.time_ns  <= s.t;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (fits_due.size() == 0 && sent_log.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic fit_t typed_fit(int slope, int offset, int removed, int count);
    fit_t f;
    f.slope = slope;
    f.offset = offset;
    f.removed = RemW'(removed);
    f.count = CntOutW'(count);
    return f;
  endfunction

  function automatic sample_t mk(logic [XW-1:0] x, logic [YW-1:0] y, logic [TW-1:0] t);
    sample_t s;
    s.x = x;
    s.y = y;
    s.t = t;
    s.pinned = 1'b0;
    s.fit = typed_fit(0, 0, 0, 0);
    return s;
  endfunction

  function automatic sample_t pin(sample_t s, fit_t f);
    s.pinned = 1'b1;
    s.fit = f;
    return s;
  endfunction

  sample_t         directed [$];
  longint unsigned now_ns;
  longint unsigned ages [6];
  longint unsigned epss [6];

  initial begin
    sample_t s;
    longint unsigned span, r64;
    in_if.valid = 1'b0;
    in_if.size_log = '0;
    in_if.rtt = '0;
    in_if.time_ns = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = RegMaxAge;
    cfg_if.data = '0;
    max_age = MaxAgeRst;
    det_eps = DetEpsRst;
    for (int i = 0; i < Depth; i++) begin
      ring_x[i] = '0;
      ring_y[i] = '0;
      ring_t[i] = 0;
      ring_live[i] = 1'b0;
    end
    wr_slot = Depth - 1;
    n_sum = 0; x_sum = 0; xx_sum = 0; y_sum = 0; xy_sum = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single point, two-point extremes, full expiry
    directed.push_back(pin(mk(16'hFFFF, 24'hFF_FFFF, 63'd1),
                           typed_fit(0, 16777215, 0, 1)));
    directed.push_back(pin(mk(16'h0000, 24'h00_0000, 63'd2), typed_fit(256, 0, 0, 2)));
    directed.push_back(pin(mk(16'd100, 24'd7, 63'd5000000100), typed_fit(0, 7, 2, 1)));
    // negative intercept beyond 32 bits
    directed.push_back(mk(16'd65534, 24'd0, 63'd10000000200));
    directed.push_back(mk(16'd65535, 24'hFF_FFFF, 63'd10000000201));
    // positive intercept beyond 32 bits, after the old pair expires
    directed.push_back(mk(16'd65534, 24'hFF_FFFF, 63'd20000000000));
    directed.push_back(mk(16'd65535, 24'd0, 63'd20000000001));
    // time going backwards, then timestamp zero
    directed.push_back(mk(16'd4096, 24'd300, 63'd1000));
    directed.push_back(mk(16'd8192, 24'd500, 63'd0));
    // top timestamp bit, clears the window
    directed.push_back(mk(16'h5555, 24'hAAAAAA, 63'h7FFF_FFFF_FFFF_FFFF));
    directed.push_back(mk(16'hAAAA, 24'h555555, 63'h7FFF_FFFF_FFFF_FFFF));
    directed.push_back(mk(16'hAAAA, 24'h555556, 63'h7FFF_FFFF_FFFF_FFFF));
    foreach (directed[k]) send_sample(directed[k]);
    drain();

    // overwrite of a live slot: fill the ring past its depth at one time
    for (int k = 0; k < Depth + 4; k++)
      send_sample(mk(XW'($urandom), YW'($urandom), 63'h7FFF_FFFF_FFFF_FFFF));
    drain();

    ages[0] = MaxAgeRst;        epss[0] = DetEpsRst;
    ages[1] = 0;                epss[1] = 0;
    ages[2] = 64'hFF_FFFF_FFFF; epss[2] = 64'hFFFF_FFFF;
    ages[3] = 1000;             epss[3] = 1000;
    ages[4] = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
    epss[4] = $urandom;
    ages[5] = 64'hFF_FFFF_FFFF; epss[5] = 0;
    now_ns = 1;

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegMaxAge, ages[ph]);
      write_reg(RegDetEps, epss[ph]);
      idle_on = (ph != 2);         // one phase runs flat out
      span = ages[ph] / 16 + 4;
      for (int k = 0; k < 165; k++) begin
        if (ph == 3 && k == 40) hold_req = HoldCycles;  // fill up and stall the input
        r64 = {$urandom, $urandom};
        case ($urandom_range(99))
          0, 1:    now_ns = r64 & 64'h7FFF_FFFF_FFFF_FFFF;  // jump anywhere
          2:       now_ns = 0;
          3, 4:    now_ns = now_ns - (now_ns > 1000 ? $urandom_range(1000) : 0);
          default: now_ns = now_ns + r64 % span;
        endcase
        if (now_ns > 64'h7FFF_FFFF_FFFF_FFFF) now_ns = 64'h7FFF_FFFF_FFFF_FFFF;
        s = ($urandom_range(1))
          ? mk(XW'($urandom), YW'($urandom), now_ns[TW-1:0])
          : mk(XW'(16'd8000 + $urandom_range(400)), YW'(24'd2000 + $urandom_range(3000)),
               now_ns[TW-1:0]);
        send_sample(s);
      end
      // sender pauses until every result is back
      drain();
    end

    write_reg(RegMaxAge, MaxAgeRst);
    write_reg(RegDetEps, DetEpsRst);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && fits_due.size() == 0)
      $display("windowed_least_squares_line_fit regression: pass");
    else
      $display("windowed_least_squares_line_fit regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("windowed_least_squares_line_fit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/wlsf_pkg.sv
sv/wlsf_if.sv
sv/wlsf_ring.sv
sv/wlsf_alu.sv
sv/windowed_least_squares_line_fit.sv
verif/tb_windowed_least_squares_line_fit.sv
